// ----- hw/rtl/dcfr_pkg.sv -----
// Shared types and constants for the dimmer channel frame receiver.
`timescale 1ns / 1ps

package dcfr_pkg;

    localparam int NUM_CHANNELS = 8;      // default channel count
    localparam int MAX_OUT      = 8;      // channel writes per received byte, at most
    localparam int SLOT_W       = 10;
    localparam int CAP_W        = 4;

    localparam logic [7:0]        CHECK_SEED       = 8'h16;
    localparam logic [7:0]        LIGHT_START_CODE = 8'h00;
    localparam logic [SLOT_W-1:0] MAX_SLOT         = 10'd512;

    // configuration register indexes
    localparam logic CFG_OP_MODE       = 1'b0;
    localparam logic CFG_START_ADDRESS = 1'b1;

    // operating modes
    localparam logic MODE_COMMAND = 1'b0;
    localparam logic MODE_DMX     = 1'b1;

    // one unit of output work: count writes to channels base, base+1, ...
    typedef struct packed {
        logic [2:0]                base;
        logic [3:0]                count;
        logic [MAX_OUT-1:0][7:0]   levels;
    } t_job;

endpackage

// ----- hw/rtl/dcfr_front.sv -----
// Front end: byte classification, frame window, checksum and DMX slot tracking.
`timescale 1ns / 1ps

module dcfr_front #(
    parameter int NUM_CHANNELS = dcfr_pkg::NUM_CHANNELS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [7:0]               i_rx_byte,
    input  logic                     i_framing_error,
    input  logic                     i_parity_error,
    input  logic                     i_overrun_error,
    input  logic                     i_op_mode,
    input  logic [9:0]               i_start_address,
    output logic                     o_push,
    output dcfr_pkg::t_job           o_job
);

    localparam int FL     = NUM_CHANNELS + 2;
    localparam int N_EMIT = (NUM_CHANNELS < dcfr_pkg::MAX_OUT) ? NUM_CHANNELS
                                                               : dcfr_pkg::MAX_OUT;
    localparam int IDX_W  = $clog2(FL);
    localparam int FILL_W = $clog2(FL + 1);

    logic [7:0]                      r_win [FL];
    logic [FILL_W-1:0]               r_fill, n_fill;
    logic [7:0]                      r_acc, n_acc;     // seed + sum of window[0..FL-2]
    logic                            r_resync, n_resync;
    logic                            r_brk, n_brk;
    logic                            r_scok, n_scok;
    logic [dcfr_pkg::SLOT_W-1:0]     r_slot, n_slot;
    logic [dcfr_pkg::CAP_W-1:0]      r_cap, n_cap;

    logic                            win_wr;
    logic                            win_shift;
    logic [IDX_W-1:0]                win_idx;

    always_comb begin
        logic [FILL_W-1:0] fill_eff;
        logic [7:0]        acc_eff;
        logic [7:0]        acc_slide;
        logic [7:0]        addr;
        logic              good;
        logic [10:0]       want_slot;

        n_fill    = r_fill;
        n_acc     = r_acc;
        n_resync  = r_resync;
        n_brk     = r_brk;
        n_scok    = r_scok;
        n_slot    = r_slot;
        n_cap     = r_cap;
        win_wr    = 1'b0;
        win_shift = 1'b0;
        o_push    = 1'b0;
        o_job     = '0;
        good      = 1'b0;

        fill_eff  = (r_fill >= FILL_W'(FL)) ? '0 : r_fill;
        acc_eff   = (r_fill >= FILL_W'(FL)) ? dcfr_pkg::CHECK_SEED : r_acc;
        win_idx   = fill_eff[IDX_W-1:0];
        acc_slide = r_acc - r_win[0] + r_win[FL-1];
        want_slot = {1'b0, i_start_address} + 11'(r_cap);
        addr      = r_resync ? r_win[1] : r_win[0];

        for (int i = 0; i < N_EMIT; i++) begin
            o_job.levels[i] = r_resync ? r_win[2 + i] : r_win[1 + i];
        end

        if (i_accept) begin
            if (i_op_mode == dcfr_pkg::MODE_COMMAND) begin
                if (!(i_framing_error || i_parity_error || i_overrun_error)) begin
                    if (!r_resync) begin
                        win_wr = 1'b1;
                        if (win_idx != IDX_W'(FL - 1)) begin
                            n_acc  = acc_eff + i_rx_byte;
                            n_fill = fill_eff + 1'b1;
                        end else if (acc_eff == i_rx_byte) begin
                            good   = 1'b1;
                            n_fill = '0;
                            n_acc  = dcfr_pkg::CHECK_SEED;
                        end else begin
                            // bad checksum: window stays full, go sliding
                            n_resync = 1'b1;
                            n_fill   = FILL_W'(FL);
                            n_acc    = acc_eff;
                        end
                    end else begin
                        win_shift = 1'b1;
                        if (acc_slide == i_rx_byte) begin
                            good     = 1'b1;
                            n_resync = 1'b0;
                            n_fill   = '0;
                            n_acc    = dcfr_pkg::CHECK_SEED;
                        end else begin
                            n_fill = FILL_W'(FL);
                            n_acc  = acc_slide;
                        end
                    end
                    if (good && i_start_address == {2'b00, addr}) begin
                        o_push      = 1'b1;
                        o_job.base  = 3'd0;
                        o_job.count = 4'(N_EMIT);
                    end
                end
            end else begin
                if (i_framing_error) begin
                    n_brk  = 1'b1;
                    n_scok = 1'b0;
                    n_slot = '0;
                    n_cap  = '0;
                end else if (r_brk) begin
                    if (r_slot == '0) begin
                        n_scok = (i_rx_byte == dcfr_pkg::LIGHT_START_CODE);
                    end else if (r_scok && r_cap < dcfr_pkg::CAP_W'(N_EMIT) &&
                                 {1'b0, r_slot} == want_slot) begin
                        o_push          = 1'b1;
                        o_job.base      = 3'(r_cap);
                        o_job.count     = 4'd1;
                        o_job.levels    = '0;
                        o_job.levels[0] = i_rx_byte;
                        n_cap           = r_cap + 1'b1;
                    end
                    if (r_slot < dcfr_pkg::MAX_SLOT) begin
                        n_slot = r_slot + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_acc    <= dcfr_pkg::CHECK_SEED;
            r_resync <= 1'b0;
            r_brk    <= 1'b0;
            r_scok   <= 1'b0;
            r_slot   <= '0;
            r_cap    <= '0;
        end else begin
            r_fill   <= n_fill;
            r_acc    <= n_acc;
            r_resync <= n_resync;
            r_brk    <= n_brk;
            r_scok   <= n_scok;
            r_slot   <= n_slot;
            r_cap    <= n_cap;
        end
    end

    // window bytes: indexed fill while aligned, shift line while sliding
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < FL; i++) begin
            if (win_shift) begin
                r_win[i] <= (i == FL - 1) ? i_rx_byte : r_win[(i + 1) % FL];
            end else if (win_wr && win_idx == IDX_W'(i)) begin
                r_win[i] <= i_rx_byte;
            end
        end
    end

endmodule

// ----- hw/rtl/dcfr_queue.sv -----
// Two-entry job queue between front and back.
`timescale 1ns / 1ps

module dcfr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dcfr_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output dcfr_pkg::t_job  o_job
);

    dcfr_pkg::t_job r_mem [2];
    logic           r_wptr, r_rptr;
    logic [1:0]     r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

// ----- hw/rtl/dcfr_back.sv -----
// Back end: expands queued jobs into single channel writes.
`timescale 1ns / 1ps

module dcfr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  dcfr_pkg::t_job  i_q_job,
    output logic            o_pop,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output logic [2:0]      o_channel,
    output logic [7:0]      o_level,
    output logic            o_last
);

    dcfr_pkg::t_job r_job;
    logic [2:0]     r_idx;
    logic           r_busy;
    logic           done;

    assign o_out_valid = r_busy;
    assign o_channel   = r_job.base + r_idx;
    assign o_level     = r_job.levels[r_idx];
    assign o_last      = ({1'b0, r_idx} == r_job.count - 4'd1);
    assign done        = r_busy && !i_out_stall && o_last;
    assign o_pop       = i_q_valid && (!r_busy || done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (r_busy && !i_out_stall) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
    end

endmodule

// ----- hw/rtl/dimmer_channel_frame_receiver.sv -----
// Top level of the dimmer channel frame receiver: config registers, front, queue, back.
`timescale 1ns / 1ps

// Channel   Handshake                     Payload
// --------  ----------------------------  -------------------------------------------
// in        i_in_valid / o_in_stall       i_rx_byte, i_framing_error, i_parity_error,
//                                         i_overrun_error
// out       o_out_valid / i_out_stall     o_channel, o_level, o_last
// cfg       i_cfg_we (no handshake back)  i_cfg_index, i_cfg_wdata
//
// The front end takes one byte per cycle while the queue is not full and settles it
// in that cycle; a transaction that causes channel writes leaves a job in a
// two-entry queue. The back end drives one channel write per cycle unless the output
// stalls; a matched command frame gives at most eight writes. Other bytes
// cause at most one write, and input runs at one byte per cycle until the queue fills.
// o_in_stall is high only while the queue is full. An output stall holds the
// current write and fills the queue; the front keeps accepting until then.
// Reset (synchronous, active low) clears all control state.

module dimmer_channel_frame_receiver #(
    parameter int NUM_CHANNELS = dcfr_pkg::NUM_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_framing_error,
    input  logic        i_parity_error,
    input  logic        i_overrun_error,
    // channel write channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_channel,
    output logic [7:0]  o_level,
    output logic        o_last,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [9:0]  i_cfg_wdata
);

    logic           r_op_mode;
    logic [9:0]     r_start_address;

    logic           in_accept;
    logic           push;
    logic           pop;
    logic           q_valid;
    logic           q_full;
    dcfr_pkg::t_job push_job;
    dcfr_pkg::t_job head_job;

    // config is only to be written while idle (the block does not enforce it), so the front reads it directly
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode       <= dcfr_pkg::MODE_COMMAND;
            r_start_address <= 10'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dcfr_pkg::CFG_OP_MODE:       r_op_mode       <= i_cfg_wdata[0];
                dcfr_pkg::CFG_START_ADDRESS: r_start_address <= i_cfg_wdata;
            endcase
        end
    end

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    dcfr_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_rx_byte       (i_rx_byte),
        .i_framing_error (i_framing_error),
        .i_parity_error  (i_parity_error),
        .i_overrun_error (i_overrun_error),
        .i_op_mode       (r_op_mode),
        .i_start_address (r_start_address),
        .o_push          (push),
        .o_job           (push_job)
    );

    dcfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (head_job)
    );

    dcfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (head_job),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_channel   (o_channel),
        .o_level     (o_level),
        .o_last      (o_last)
    );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the dimmer channel frame receiver.
`timescale 1ns / 1ps

module testbench;

    localparam int FRAME_BYTES     = dcfr_pkg::NUM_CHANNELS + 2;
    localparam int WRITES_PER_BYTE = (dcfr_pkg::NUM_CHANNELS < dcfr_pkg::MAX_OUT)
                                     ? dcfr_pkg::NUM_CHANNELS : dcfr_pkg::MAX_OUT;
    localparam int SETTLE_CYCLES   = 20;    // front settles each byte at once, queue holds two jobs
    localparam int QUIET_LIMIT     = 3000;  // cycles with no transaction before giving up

    typedef struct packed {
        logic [2:0] channel;
        logic [7:0] level;
        logic       is_last;
    } t_channel_write;

    // Tracks receiver state and the channel writes still owed by the block.
    class level_scoreboard;
        t_channel_write expected_writes[$];
        int             mismatches;
        logic           mode;
        logic [9:0]     address;
        logic [7:0]     window [FRAME_BYTES];
        int unsigned    fill;
        bit             sliding;
        bit             break_seen;
        bit             start_ok;
        int unsigned    slot;
        int unsigned    captured;

        function new();
            mode       = dcfr_pkg::MODE_COMMAND;
            address    = 10'd1;
            foreach (window[i]) window[i] = 8'h00;
            fill       = 0;
            sliding    = 0;
            break_seen = 0;
            start_ok   = 0;
            slot       = 0;
            captured   = 0;
            mismatches = 0;
        endfunction

        function void set_register(logic index, logic [9:0] value);
            if (index == dcfr_pkg::CFG_OP_MODE) begin
                mode = value[0];
            end else begin
                address = value;
            end
        endfunction

        function bit window_checks();
            logic [7:0] total;
            total = dcfr_pkg::CHECK_SEED;
            for (int i = 0; i < FRAME_BYTES - 1; i++) total += window[i];
            return total == window[FRAME_BYTES-1];
        endfunction

        // A checked frame only drives the dimmers when its address byte matches.
        function void queue_frame_writes();
            t_channel_write w;
            if (address != {2'b00, window[0]}) return;
            for (int i = 0; i < WRITES_PER_BYTE; i++) begin
                w.channel = 3'(i);
                w.level   = window[1+i];
                w.is_last = (i == WRITES_PER_BYTE - 1);
                expected_writes.push_back(w);
            end
        endfunction

        function void command_byte(logic [7:0] b);
            if (!sliding) begin
                if (fill >= FRAME_BYTES) fill = 0;
                window[fill] = b;
                fill++;
                if (fill < FRAME_BYTES) return;
                if (window_checks()) begin
                    fill = 0;
                    queue_frame_writes();
                end else begin
                    sliding = 1;
                end
            end else begin
                for (int i = 0; i < FRAME_BYTES - 1; i++) window[i] = window[i+1];
                window[FRAME_BYTES-1] = b;
                fill = FRAME_BYTES;
                if (window_checks()) begin
                    sliding = 0;
                    fill    = 0;
                    queue_frame_writes();
                end
            end
        endfunction

        function void dmx_byte(logic [7:0] b, logic brk);
            t_channel_write w;
            if (brk) begin
                break_seen = 1;
                start_ok   = 0;
                slot       = 0;
                captured   = 0;
                return;
            end
            if (!break_seen) return;
            if (slot == 0) begin
                start_ok = (b == dcfr_pkg::LIGHT_START_CODE);
            end else if (start_ok && captured < dcfr_pkg::NUM_CHANNELS &&
                         captured < dcfr_pkg::MAX_OUT && slot == address + captured) begin
                w.channel = 3'(captured);
                w.level   = b;
                w.is_last = 1'b1;
                expected_writes.push_back(w);
                captured++;
            end
            if (slot < dcfr_pkg::MAX_SLOT) slot++;
        endfunction

        function void note_byte(logic [7:0] b, logic fe, logic pe, logic oe);
            if (mode == dcfr_pkg::MODE_COMMAND) begin
                if (fe || pe || oe) return;   // errored bytes are dropped outright
                command_byte(b);
            end else begin
                dmx_byte(b, fe);              // parity and overrun do not matter here
            end
        endfunction

        function void check_write(logic [2:0] channel, logic [7:0] level, logic is_last);
            t_channel_write want;
            if (expected_writes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected write: channel %0d level %0d last %0d",
                         $time, channel, level, is_last);
                return;
            end
            want = expected_writes.pop_front();
            if (channel !== want.channel) begin
                mismatches++;
                $display("%0t: channel mismatch: expected %0d, actual %0d",
                         $time, want.channel, channel);
            end
            if (level !== want.level) begin
                mismatches++;
                $display("%0t: level mismatch: expected %0d, actual %0d",
                         $time, want.level, level);
            end
            if (is_last !== want.is_last) begin
                mismatches++;
                $display("%0t: last mismatch: expected %0d, actual %0d",
                         $time, want.is_last, is_last);
            end
        endfunction
    endclass

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_in_valid      = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_rx_byte       = 8'h00;
    logic       i_framing_error = 1'b0;
    logic       i_parity_error  = 1'b0;
    logic       i_overrun_error = 1'b0;
    logic       o_out_valid;
    logic       i_out_stall     = 1'b0;
    logic [2:0] o_channel;
    logic [7:0] o_level;
    logic       o_last;
    logic       i_cfg_we        = 1'b0;
    logic       i_cfg_index     = 1'b0;
    logic [9:0] i_cfg_wdata     = 10'd0;

    bit              sender_idles   = 1;
    bit              receiver_idles = 1;
    int unsigned     stall_left     = 0;
    int unsigned     run_left       = 0;
    int unsigned     quiet_cycles   = 0;
    level_scoreboard board;

    dimmer_channel_frame_receiver u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .i_framing_error (i_framing_error),
        .i_parity_error  (i_parity_error),
        .i_overrun_error (i_overrun_error),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_channel       (o_channel),
        .o_level         (o_level),
        .o_last          (o_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Output side: check accepted writes, drive stall bursts, watch for a hang.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            board.check_write(o_channel, o_level, o_last);
            quiet_cycles = 0;
        end else if (i_rst_n && i_in_valid && o_in_stall === 1'b0) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (stall_left != 0) begin
            stall_left--;
        end else if (run_left != 0) begin
            run_left--;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 13);
        end else begin
            run_left = $urandom_range(1, 24);
        end
        i_out_stall <= receiver_idles && stall_left != 0;
    end

    // One input transaction; the payload holds until the block takes it.
    task automatic send_byte(logic [7:0] b, logic fe = 1'b0, logic pe = 1'b0,
                             logic oe = 1'b0);
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_rx_byte       <= b;
        i_framing_error <= fe;
        i_parity_error  <= pe;
        i_overrun_error <= oe;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        board.note_byte(b, fe, pe, oe);
    endtask

    // Hold off input until every owed write is out and the block is quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.expected_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic index, logic [9:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_register(index, value);
    endtask

    // Address, levels (channel 0 in the low byte), checksum; optionally spoiled.
    task automatic send_command_frame(logic [7:0] addr_byte, logic [63:0] levels,
                                      bit bad_sum, bit with_errors);
        logic [7:0] frame [FRAME_BYTES];
        logic [7:0] total;
        logic [2:0] flags;
        frame[0] = addr_byte;
        total    = dcfr_pkg::CHECK_SEED + addr_byte;
        for (int i = 0; i < dcfr_pkg::NUM_CHANNELS; i++) begin
            frame[1+i] = levels[8*i +: 8];
            total += levels[8*i +: 8];
        end
        frame[FRAME_BYTES-1] = bad_sum ? total ^ 8'($urandom_range(1, 255)) : total;
        foreach (frame[i]) begin
            if (with_errors && $urandom_range(0, 5) == 0) begin
                flags = 3'($urandom_range(1, 7));
                send_byte(8'($urandom), flags[0], flags[1], flags[2]);
            end
            send_byte(frame[i]);
        end
    endtask

    // Mostly frames for this device, with foreign, corrupt and stray bytes mixed in.
    task automatic random_command_traffic(int frames);
        int         kind;
        logic [7:0] own_addr;
        own_addr = board.address[7:0];
        repeat (frames) begin
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
                send_command_frame(own_addr, {$urandom, $urandom}, 0, kind < 4);
            end else if (kind < 15) begin
                send_command_frame(own_addr ^ 8'($urandom_range(1, 255)),
                                   {$urandom, $urandom}, 0, 0);
            end else if (kind < 18) begin
                send_command_frame(own_addr, {$urandom, $urandom}, 1, 0);
            end else begin
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            end
        end
    endtask

    // Break, start code, then data slots; noisy adds flags and rare early breaks.
    task automatic send_dmx_frame(int slots, logic [7:0] start_code, bit noisy);
        logic [2:0] flags;
        flags = 3'($urandom);
        send_byte(8'($urandom), 1'b1, flags[1], flags[2]);
        send_byte(start_code);
        for (int s = 1; s <= slots; s++) begin
            flags = noisy ? 3'($urandom) : 3'b000;
            send_byte(8'($urandom), noisy && $urandom_range(0, 39) == 0, flags[1], flags[2]);
        end
    endtask

    initial begin
        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Command mode: dropped errored bytes, one matching frame, one bad checksum.
        write_register(dcfr_pkg::CFG_OP_MODE, 10'(dcfr_pkg::MODE_COMMAND));
        write_register(dcfr_pkg::CFG_START_ADDRESS, 10'd1);
        send_byte(8'hFF, 1'b1, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b0, 1'b1);
        send_command_frame(8'd1, 64'hAA55_FE7F_8001_FF00, 0, 0);
        send_command_frame(8'd1, 64'h0123_4567_89AB_CDEF, 1, 0);

        // Resync after the bad checksum, then random frames at two addresses.
        random_command_traffic(3);
        write_register(dcfr_pkg::CFG_START_ADDRESS, 10'($urandom_range(2, 255)));
        random_command_traffic(2);

        // DMX: bytes before any break are ignored, then full and partial frames.
        write_register(dcfr_pkg::CFG_OP_MODE, 10'(dcfr_pkg::MODE_DMX));
        write_register(dcfr_pkg::CFG_START_ADDRESS, 10'd1);
        repeat (3) send_byte(8'($urandom), 1'b0, 1'($urandom), 1'($urandom));
        send_dmx_frame(9, dcfr_pkg::LIGHT_START_CODE, 0);
        send_dmx_frame(8, 8'($urandom_range(1, 255)), 1);
        repeat (3) begin
            write_register(dcfr_pkg::CFG_START_ADDRESS, 10'($urandom_range(1, 8)));
            send_dmx_frame($urandom_range(4, 12),
                           ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                                       : dcfr_pkg::LIGHT_START_CODE, 1);
        end
        // Address zero and an unreachable address capture nothing.
        write_register(dcfr_pkg::CFG_START_ADDRESS, 10'd0);
        send_dmx_frame(8, dcfr_pkg::LIGHT_START_CODE, 0);
        write_register(dcfr_pkg::CFG_START_ADDRESS, 10'd1023);
        send_dmx_frame(6, dcfr_pkg::LIGHT_START_CODE, 0);

        // Back to command mode with its old state; 512 never matches an address byte.
        write_register(dcfr_pkg::CFG_OP_MODE, 10'(dcfr_pkg::MODE_COMMAND));
        write_register(dcfr_pkg::CFG_START_ADDRESS, 10'd512);
        send_command_frame(8'h00, {$urandom, $urandom}, 0, 0);
        send_command_frame(8'h00, {$urandom, $urandom}, 0, 0);
        write_register(dcfr_pkg::CFG_START_ADDRESS, 10'd255);

        // Final stretch at full rate on both sides.
        sender_idles   = 0;
        receiver_idles = 0;
        random_command_traffic(3);
        settle();

        if (board.mismatches == 0 && board.expected_writes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/dcfr_pkg.sv
hw/rtl/dcfr_front.sv
hw/rtl/dcfr_queue.sv
hw/rtl/dcfr_back.sv
hw/rtl/dimmer_channel_frame_receiver.sv
test/testbench.sv
